// File: sv/utf8_to_sjis_stream_converter_assert.svh
// Assertion macros for the UTF-8 to SJIS stream converter.
// Included by modules that check their own logic; no other dependencies.
`ifndef UTF8_TO_SJIS_STREAM_CONVERTER_ASSERT_SVH
`define UTF8_TO_SJIS_STREAM_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define U2S_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define U2S_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/u2s_pkg.sv
// Shared types, result codes and address-rule constants of the converter.
// No dependencies; used by the interfaces' users, the core and the top level.
`timescale 1ns / 1ps

package u2s_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Replacement for a bad lead byte: SJIS ideographic space
    localparam logic [7:0] SJIS_SPACE_HI = 8'h81;
    localparam logic [7:0] SJIS_SPACE_LO = 8'h40;

    // Table address of the space entry
    localparam logic [31:0] SPACE_ADDR = 32'h0000_9DCC;

    // Two-byte rule
    localparam logic [31:0] TWO_START = 32'h0000_C2A2;
    localparam logic [31:0] TWO_BASE  = 32'h0000_00B0;

    // Full-width form rule
    localparam logic [31:0] FW_START  = 32'h00EF_BC81;
    localparam logic [31:0] FW_BASE   = 32'h0003_A6A4;
    localparam logic [31:0] FW_TILDE  = 32'h0003_A8DE;

    // Three-byte rules for leads E2-E9
    localparam logic [23:0] E_START [8] = '{
        24'hE28090, 24'hE38080, 24'hE4B880, 24'hE58085,
        24'hE6808E, 24'hE78081, 24'hE88080, 24'hE98080
    };
    localparam logic [19:0] E_BASE [8] = '{
        20'h01EEC, 20'h09DCC, 20'h11CCC, 20'h12BCC,
        20'h1AAC2, 20'h229A6, 20'h2A8A4, 20'h327A4
    };

    // One input request
    typedef struct packed {
        logic       func;
        logic [7:0] text_byte;
        logic       end_of_text;
        logic [7:0] table_first;
        logic [7:0] table_second;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sjis_byte;
        logic [19:0] table_address;
        logic [15:0] text_length;
        logic        last_of_run;
    } t_result;

    // All results of one input request
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_res_set;

    typedef struct packed {
        logic        hit;
        logic [31:0] addr;
    } t_addr_hit;

    // Table offset of a collected character; hit is low where no rule applies
    function automatic t_addr_hit addr_rule(input logic [7:0] l, input logic [7:0] s,
                                            input logic [7:0] t);
        t_addr_hit  r;
        logic [31:0] code;
        logic [2:0]  idx;
        r    = '0;
        code = {8'h00, l, s, t};
        idx  = 3'(l - 8'hE2);
        if (l >= 8'hC2 && l <= 8'hD1) begin
            r.hit  = 1'b1;
            r.addr = ((32'({l, s}) - TWO_START) << 1) + TWO_BASE;
        end else if (l >= 8'hE2 && l <= 8'hE9 && s >= 8'h80) begin
            r.hit  = 1'b1;
            r.addr = ((code - 32'(E_START[idx])) << 1) + 32'(E_BASE[idx]);
        end else if (l == 8'hEF && s >= 8'hBC) begin
            r.hit = 1'b1;
            if (s == 8'hBD && t == 8'h9E) begin
                r.addr = FW_TILDE;
            end else begin
                r.addr = ((code - FW_START) << 1) + FW_BASE;
            end
        end
        return r;
    endfunction

endpackage

// File: sv/u2s_in_if.sv
// Input channel of the converter: valid/ready plus one text byte or table response.
// No dependencies.
`timescale 1ns / 1ps

interface u2s_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic [7:0] table_first;
    logic [7:0] table_second;

    modport source (output valid, func, text_byte, end_of_text, table_first,
                    table_second, input ready);
    modport sink   (input valid, func, text_byte, end_of_text, table_first,
                    table_second, output ready);
endinterface

// File: sv/u2s_out_if.sv
// Output channel of the converter: valid/ready plus one result.
// No dependencies.
`timescale 1ns / 1ps

interface u2s_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  sjis_byte;
    logic [19:0] table_address;
    logic [15:0] text_length;
    logic        last_of_run;

    modport source (output valid, kind, sjis_byte, table_address, text_length,
                    last_of_run, input ready);
    modport sink   (input valid, kind, sjis_byte, table_address, text_length,
                    last_of_run, output ready);
endinterface

// File: sv/u2s_core.sv
// Conversion state and per-request result logic of the converter.
// Depends on u2s_pkg.
`timescale 1ns / 1ps

module u2s_core
    import u2s_pkg::*;
#(
    parameter int ADDRESS_BITS = 20,
    parameter int LENGTH_BITS  = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_res_set o_res
);

    logic [1:0]              r_need,   n_need;
    logic [7:0]              r_lead,   n_lead;
    logic [7:0]              r_second, n_second;
    logic [ADDRESS_BITS-1:0] r_addr,   n_addr;
    logic                    r_await,  n_await;
    logic                    r_endp,   n_endp;
    logic [LENGTH_BITS-1:0]  r_count,  n_count;

    t_res_set   res;
    logic [1:0] k;
    logic       do_req;
    logic       req_end;
    logic [7:0] req_l;
    logic [7:0] req_s;
    logic [7:0] req_t;
    logic [7:0] b;
    logic [7:0] f;
    t_addr_hit  rule;
    logic [31:0] addr_ext;
    logic [31:0] len_ext;

    // Offset of the character being requested
    assign rule = addr_rule(req_l, req_s, req_t);

    // Work out the results of the current request and the next state
    always_comb begin
        n_need   = r_need;
        n_lead   = r_lead;
        n_second = r_second;
        n_addr   = r_addr;
        n_await  = r_await;
        n_endp   = r_endp;
        n_count  = r_count;
        res      = '0;
        k        = 2'd0;
        do_req   = 1'b0;
        req_end  = 1'b0;
        req_l    = r_lead;
        req_s    = r_second;
        req_t    = 8'h00;
        b        = i_item.text_byte;
        f        = i_item.table_first;
        addr_ext = '0;
        len_ext  = '0;

        if (i_item.func) begin
            // Table response: emit one or two bytes, then the end if pending
            if (r_await) begin
                res.res[0].kind      = KIND_BYTE;
                res.res[0].sjis_byte = f;
                n_count              = n_count + LENGTH_BITS'(1);
                k                    = 2'd1;
                if (!(f >= 8'hA1 && f <= 8'hDF)) begin
                    res.res[1].kind      = KIND_BYTE;
                    res.res[1].sjis_byte = i_item.table_second;
                    n_count              = n_count + LENGTH_BITS'(1);
                    k                    = 2'd2;
                end
                if (r_endp) begin
                    len_ext                = 32'(n_count);
                    res.res[k].kind        = KIND_END;
                    res.res[k].text_length = len_ext[15:0];
                    k                      = k + 2'd1;
                    n_count                = '0;
                    n_addr                 = ADDRESS_BITS'(SPACE_ADDR);
                end
                n_await = 1'b0;
                n_endp  = 1'b0;
            end
        end else if (!r_await) begin
            // Text byte: collect trailing bytes, pass ASCII, repair bad leads
            if (r_need == 2'd2) begin
                if (i_item.end_of_text) begin
                    do_req  = 1'b1;
                    req_end = 1'b1;
                    req_s   = b;
                end else begin
                    n_second = b;
                    n_need   = 2'd1;
                end
            end else if (r_need == 2'd1) begin
                do_req  = 1'b1;
                req_end = i_item.end_of_text;
                if (r_lead >= 8'hC2 && r_lead <= 8'hD1) begin
                    req_s = b;
                end else begin
                    req_t = b;
                end
            end else if ((b >= 8'hC2 && b <= 8'hD1) || (b >= 8'hE2 && b <= 8'hEF)) begin
                n_lead   = b;
                n_second = 8'h00;
                if (i_item.end_of_text) begin
                    do_req  = 1'b1;
                    req_end = 1'b1;
                    req_l   = b;
                    req_s   = 8'h00;
                end else begin
                    n_need = (b <= 8'hD1) ? 2'd1 : 2'd2;
                end
            end else begin
                if (b >= 8'h20 && b <= 8'h7E) begin
                    res.res[0].kind      = KIND_BYTE;
                    res.res[0].sjis_byte = b;
                    n_count              = n_count + LENGTH_BITS'(1);
                    k                    = 2'd1;
                end else begin
                    res.res[0].kind      = KIND_BYTE;
                    res.res[0].sjis_byte = SJIS_SPACE_HI;
                    res.res[1].kind      = KIND_BYTE;
                    res.res[1].sjis_byte = SJIS_SPACE_LO;
                    n_count              = n_count + LENGTH_BITS'(2);
                    k                    = 2'd2;
                end
                if (i_item.end_of_text) begin
                    len_ext                = 32'(n_count);
                    res.res[k].kind        = KIND_END;
                    res.res[k].text_length = len_ext[15:0];
                    k                      = k + 2'd1;
                    n_count                = '0;
                    n_addr                 = ADDRESS_BITS'(SPACE_ADDR);
                end
            end
        end

        // Issue a table read; keep the last address where no rule applies
        if (do_req) begin
            if (rule.hit) begin
                n_addr = ADDRESS_BITS'(rule.addr);
            end
            addr_ext                 = 32'(n_addr);
            res.res[0].kind          = KIND_REQ;
            res.res[0].table_address = addr_ext[19:0];
            k                        = 2'd1;
            n_need                   = 2'd0;
            n_await                  = 1'b1;
            n_endp                   = req_end;
        end

        // Mark the final result of this request
        if (k != 2'd0) begin
            res.res[k - 2'd1].last_of_run = 1'b1;
        end
        res.cnt = k;
    end

    assign o_res = res;

    // Advance the state when the request moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need   <= 2'd0;
            r_lead   <= 8'h00;
            r_second <= 8'h00;
            r_addr   <= ADDRESS_BITS'(SPACE_ADDR);
            r_await  <= 1'b0;
            r_endp   <= 1'b0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_need   <= n_need;
            r_lead   <= n_lead;
            r_second <= n_second;
            r_addr   <= n_addr;
            r_await  <= n_await;
            r_endp   <= n_endp;
            r_count  <= n_count;
        end
    end

endmodule

// File: sv/utf8_to_sjis_stream_converter.sv
// UTF-8 to SJIS stream converter.
// i_in carries either a UTF-8 text byte (func = 0, end_of_text marks the last
// byte of a string) or a conversion table response (func = 1). o_out carries
// results: SJIS bytes, table read requests and an end result with the
// string's SJIS length. last_of_run flags the final result of a request.
// A table read request must be answered on i_in before more text is taken
// into account; text bytes sent while a request is open are dropped.
// A request is registered in the input register on acceptance; its results are
// computed from it and loaded into the result buffer once that buffer is free.
// Throughput: one result per cycle on o_out while o_out is ready; a request
// with n results (up to 3) holds the result buffer until all have left, while
// the input register takes one further request, so one request per cycle for
// single-result traffic while o_out is ready.
// Requests with no result (collected lead bytes) load nothing into the buffer.
// Reset (synchronous, active low) empties both stages and restarts the
// string: count zero, last table address at the space entry.
// When o_out stalls, the result buffer holds and i_in.ready drops once the
// input register is also full.
// Depends on u2s_pkg, u2s_in_if, u2s_out_if, u2s_core and the assertion header.
`timescale 1ns / 1ps

`include "utf8_to_sjis_stream_converter_assert.svh"

module utf8_to_sjis_stream_converter
    import u2s_pkg::*;
#(
    parameter int ADDRESS_BITS = 20,
    parameter int LENGTH_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u2s_in_if.sink    i_in,
    u2s_out_if.source o_out
);

    t_in_item       r_in;
    logic           r_in_vld;
    t_result [2:0]  r_buf;
    logic [1:0]     r_buf_cnt;

    t_in_item       in_item;
    t_res_set       core_res;
    logic           buf_free;
    logic           s1_fire;
    logic           in_take;
    logic           out_take;

    // Pack the incoming request
    assign in_item.func         = i_in.func;
    assign in_item.text_byte    = i_in.text_byte;
    assign in_item.end_of_text  = i_in.end_of_text;
    assign in_item.table_first  = i_in.table_first;
    assign in_item.table_second = i_in.table_second;

    // Handshake: buffer frees when empty or its last result leaves now
    assign out_take = o_out.valid && o_out.ready;
    assign buf_free = (r_buf_cnt == 2'd0) || (r_buf_cnt == 2'd1 && o_out.ready);
    assign s1_fire  = r_in_vld && buf_free;
    assign i_in.ready = !r_in_vld || s1_fire;
    assign in_take  = i_in.valid && i_in.ready;

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (s1_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
    end

    u2s_core #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    // Load new results or shift the buffer down as results leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_cnt <= 2'd0;
        end else if (s1_fire && core_res.cnt != 2'd0) begin
            r_buf_cnt <= core_res.cnt;
        end else if (out_take) begin
            r_buf_cnt <= r_buf_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && core_res.cnt != 2'd0) begin
            r_buf <= core_res.res;
        end else if (out_take) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    // Drive the head of the buffer
    assign o_out.valid         = (r_buf_cnt != 2'd0);
    assign o_out.kind          = r_buf[0].kind;
    assign o_out.sjis_byte     = r_buf[0].sjis_byte;
    assign o_out.table_address = r_buf[0].table_address;
    assign o_out.text_length   = r_buf[0].text_length;
    assign o_out.last_of_run   = r_buf[0].last_of_run;

    // A stalled buffer neither loads nor drains
    `U2S_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, (r_buf_cnt != 2'd0) && !o_out.ready,
                     r_buf_cnt == $past(r_buf_cnt), "result buffer changed while stalled")
    // The last buffered result closes its run
    `U2S_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, r_buf_cnt == 2'd1, r_buf[0].last_of_run,
                    "last result lacks last_of_run")
    // Input stalls only behind a full input register
    `U2S_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !i_in.ready, r_in_vld && !buf_free,
                    "input stalled with room")

endmodule
